### rtl/dcnv_pkg.sv
// Shared constants, reciprocals, tables and inter-stage types of the date converter.
`default_nettype none

package dcnv_pkg;

    localparam int DN_MIN       = -719528;
    localparam int DN_MAX       = 2932896;
    localparam int YEAR_MAX     = 9999;
    localparam int YEARS_PER_ERA = 400;
    localparam int ERA_DAYS     = 146097;
    localparam int EPOCH_SHIFT  = 865565;
    localparam int DAYS_PER_YEAR = 365;

    localparam logic [12:0] DIV25_M    = 13'(((64'd1 << 17) + 64'd24) / 64'd25);
    localparam logic [22:0] DIV_ERA_M  = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
    localparam logic [17:0] DIV1460_M  = 18'(((64'd1 << 28) + 64'd1459) / 64'd1460);
    localparam logic [17:0] DIV36524_M = 18'(((64'd1 << 33) + 64'd36523) / 64'd36524);
    localparam logic [17:0] DIV365_M   = 18'(((64'd1 << 26) + 64'd364) / 64'd365);
    localparam logic [17:0] DIV7_M     = 18'(((64'd1 << 20) + 64'd6) / 64'd7);
    localparam logic [9:0]  DIV100_M   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [11:0] DIV153_M   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

    typedef struct packed {
        logic signed [22:0] zsat;
        logic [21:0]        zs;
    } dcnv_front_t;

    typedef struct packed {
        logic signed [22:0] zsat;
        logic [4:0]         era;
        logic [17:0]        doe;
    } dcnv_era_t;

    // Day of a March-based year on which month index mp begins
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] mm, input logic leap);
        logic [4:0] r;
        case (mm) inside
            4'd2:                      r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
            default:                   r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/dcnv_req_if.sv
// Request channel: valid/ready handshake with the conversion request payload.
`default_nettype none

interface dcnv_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [22:0] day_number;
    logic [13:0]        year_in;
    logic [3:0]         month_in;
    logic [4:0]         day_in;

    modport source (
        output valid, req_type, day_number, year_in, month_in, day_in,
        input  ready
    );

    modport sink (
        input  valid, req_type, day_number, year_in, month_in, day_in,
        output ready
    );
endinterface

`default_nettype wire

### rtl/dcnv_rsp_if.sv
// Result channel: valid/ready handshake with the decoded date payload.
`default_nettype none

interface dcnv_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [22:0] day_number_out;
    logic [13:0]        year_out;
    logic [3:0]         month_out;
    logic [4:0]         day_out;
    logic [2:0]         weekday;
    logic [4:0]         month_length;

    modport source (
        output valid, day_number_out, year_out, month_out, day_out, weekday, month_length,
        input  ready
    );

    modport sink (
        input  valid, day_number_out, year_out, month_out, day_out, weekday, month_length,
        output ready
    );
endinterface

`default_nettype wire

### rtl/civil_date_day_number_converter.sv
// Top level of the proleptic Gregorian date and day number converter.
`default_nettype none

// Converts a day number (days since 1970-01-01) to year, month and day, or a
// date to its day number, and reports the weekday (0 is Sunday) and the month
// length of the resulting date. Out-of-range year and month fields are clamped and the day
// number is saturated to 0000-01-01 .. 9999-12-31. The block is a 12-stage
// pipeline of constant-reciprocal multiplies: it takes one transaction per
// cycle while the result side is not stalled. Backpressure stops only the
// stages that hold data, so gaps in the pipeline fill while the output waits.
module civil_date_day_number_converter
    import dcnv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dcnv_req_if.sink   req,
    dcnv_rsp_if.source rsp
);

    dcnv_front_t front_data;
    logic        front_valid;
    logic        era_ready;
    dcnv_era_t   era_data;
    logic        era_valid;
    logic        dec_ready;

    dcnv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .out_data  (front_data),
        .out_valid (front_valid),
        .out_ready (era_ready)
    );

    dcnv_era u_era (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (front_data),
        .in_valid  (front_valid),
        .in_ready  (era_ready),
        .out_data  (era_data),
        .out_valid (era_valid),
        .out_ready (dec_ready)
    );

    dcnv_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (era_data),
        .in_valid (era_valid),
        .in_ready (dec_ready),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

### rtl/dcnv_front.sv
// Front stages: date encoding, request select and day number saturation.
`default_nettype none

module dcnv_front
    import dcnv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dcnv_req_if.sink   req,
    output dcnv_front_t out_data,
    output logic       out_valid,
    input  wire logic  out_ready
);

    localparam int NSTG = 3;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] adv;

    logic [13:0] year_c;
    logic [3:0]  month_c;
    logic [3:0]  mp;
    logic [13:0] ys;
    logic [9:0]  doyd;

    logic               a_type_reg;
    logic signed [22:0] a_dn_reg;
    logic [13:0]        a_ys_reg;
    logic [21:0]        a_ys365_reg;
    logic [7:0]         a_d100_reg;
    logic [9:0]         a_doyd_reg;

    logic [24:0] q25;
    logic [23:0] pos;
    logic [23:0] neg;
    logic signed [23:0] z_next;
    logic signed [23:0] b_z_reg;

    logic signed [22:0] zsat;
    logic [23:0]        zs_wide;
    dcnv_front_t        c_reg;

    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign req.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= req.valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Clamp the year and month fields and form the March-based year
    always_comb
    begin
        year_c = (req.year_in > 14'(YEAR_MAX)) ? 14'(YEAR_MAX) : req.year_in;
        if (req.month_in == 4'd0)
        begin
            month_c = 4'd1;
        end
        else if (req.month_in > 4'd12)
        begin
            month_c = 4'd12;
        end
        else
        begin
            month_c = req.month_in;
        end
        mp   = (month_c > 4'd2) ? (month_c - 4'd3) : (month_c + 4'd9);
        ys   = year_c + 14'(YEARS_PER_ERA) - ((month_c <= 4'd2) ? 14'd1 : 14'd0);
        doyd = 10'(month_start(mp)) + 10'(req.day_in);
        q25  = 25'(ys[13:2]) * 25'(DIV25_M);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            a_type_reg  <= req.req_type;
            a_dn_reg    <= req.day_number;
            a_ys_reg    <= ys;
            a_ys365_reg <= 22'(ys) * 22'(DAYS_PER_YEAR);
            a_d100_reg  <= q25[24:17];
            a_doyd_reg  <= doyd;
        end
    end

    // Sum the year and day terms relative to the epoch
    always_comb
    begin
        pos = 24'(a_ys365_reg) + 24'(a_ys_reg[13:2]) + 24'(a_d100_reg[7:2])
            + 24'(a_doyd_reg);
        neg = 24'(a_d100_reg) + 24'(EPOCH_SHIFT) + 24'd1;
        z_next = a_type_reg ? signed'(pos - neg) : {a_dn_reg[22], a_dn_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            b_z_reg <= z_next;
        end
    end

    always_comb
    begin
        if (b_z_reg < 24'(DN_MIN))
        begin
            zsat = 23'(DN_MIN);
        end
        else if (b_z_reg > 24'(DN_MAX))
        begin
            zsat = 23'(DN_MAX);
        end
        else
        begin
            zsat = b_z_reg[22:0];
        end
        zs_wide = {zsat[22], zsat} + 24'(EPOCH_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            c_reg.zsat <= zsat;
            c_reg.zs   <= zs_wide[21:0];
        end
    end

    assign out_data  = c_reg;
    assign out_valid = vld_reg[NSTG-1];

endmodule

`default_nettype wire

### rtl/dcnv_era.sv
// Era stages: split the shifted day count into era and day of era.
`default_nettype none

module dcnv_era
    import dcnv_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire dcnv_front_t  in_data,
    input  wire logic         in_valid,
    output logic              in_ready,
    output dcnv_era_t         out_data,
    output logic              out_valid,
    input  wire logic         out_ready
);

    localparam int NSTG = 2;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] adv;

    logic [44:0]        eprod;
    logic [4:0]         d_era_reg;
    logic [21:0]        d_zs_reg;
    logic signed [22:0] d_zsat_reg;
    logic [21:0]        era_days;
    logic [21:0]        doe_wide;
    dcnv_era_t          e_reg;

    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign eprod = 45'(in_data.zs) * 45'(DIV_ERA_M);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            d_era_reg  <= eprod[44:40];
            d_zs_reg   <= in_data.zs;
            d_zsat_reg <= in_data.zsat;
        end
    end

    always_comb
    begin
        era_days = 22'(d_era_reg) * 22'(ERA_DAYS);
        doe_wide = d_zs_reg - era_days;
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            e_reg.zsat <= d_zsat_reg;
            e_reg.era  <= d_era_reg;
            e_reg.doe  <= doe_wide[17:0];
        end
    end

    assign out_data  = e_reg;
    assign out_valid = vld_reg[NSTG-1];

endmodule

`default_nettype wire

### rtl/dcnv_decode.sv
// Decode stages: day of era to year, month, day, weekday and month length.
`default_nettype none

module dcnv_decode
    import dcnv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dcnv_era_t  in_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    dcnv_rsp_if.source      rsp
);

    localparam int NSTG = 7;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] adv;

    // Stage F
    logic [35:0]        p1460;
    logic [35:0]        p36524;
    logic [6:0]         f_d1460_reg;
    logic [2:0]         f_d36524_reg;
    logic               f_last_reg;
    logic [17:0]        f_doe_reg;
    logic [4:0]         f_era_reg;
    logic signed [22:0] f_zsat_reg;

    // Stage G
    logic [17:0]        g_t_reg;
    logic [17:0]        g_doe_reg;
    logic [4:0]         g_era_reg;
    logic signed [22:0] g_zsat_reg;

    // Stage H
    logic [35:0]        p365;
    logic [35:0]        p7;
    logic [8:0]         h_yoe_reg;
    logic [2:0]         h_q7_reg;
    logic [17:0]        h_doe_reg;
    logic [4:0]         h_era_reg;
    logic signed [22:0] h_zsat_reg;

    // Stage I
    logic [18:0]        p100;
    logic [2:0]         rem7;
    logic [3:0]         wd_sum;
    logic [17:0]        i_y365_reg;
    logic [1:0]         i_y100_reg;
    logic [8:0]         i_yoe_reg;
    logic [17:0]        i_doe_reg;
    logic [4:0]         i_era_reg;
    logic signed [22:0] i_zsat_reg;
    logic [2:0]         i_wd_reg;

    // Stage J
    logic [17:0]        yr_days;
    logic [17:0]        doy_wide;
    logic [9:0]         yp1;
    logic               leap;
    logic [8:0]         j_doy_reg;
    logic [8:0]         j_yoe_reg;
    logic [4:0]         j_era_reg;
    logic signed [22:0] j_zsat_reg;
    logic [2:0]         j_wd_reg;
    logic               j_leap_reg;

    // Stage K
    logic [22:0]        p153;
    logic [3:0]         k_mp_reg;
    logic [8:0]         k_doy_reg;
    logic [8:0]         k_yoe_reg;
    logic [4:0]         k_era_reg;
    logic signed [22:0] k_zsat_reg;
    logic [2:0]         k_wd_reg;
    logic               k_leap_reg;

    // Stage L
    logic [3:0]         mm;
    logic [8:0]         dom;
    logic [13:0]        year_v;
    logic signed [22:0] l_zsat_reg;
    logic [13:0]        l_year_reg;
    logic [3:0]         l_month_reg;
    logic [4:0]         l_day_reg;
    logic [2:0]         l_wd_reg;
    logic [4:0]         l_mlen_reg;

    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || rsp.ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage F: leap day corrections of the day of era
    assign p1460  = 36'(in_data.doe) * 36'(DIV1460_M);
    assign p36524 = 36'(in_data.doe) * 36'(DIV36524_M);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            f_d1460_reg  <= p1460[34:28];
            f_d36524_reg <= p36524[35:33];
            f_last_reg   <= (in_data.doe == 18'(ERA_DAYS - 1));
            f_doe_reg    <= in_data.doe;
            f_era_reg    <= in_data.era;
            f_zsat_reg   <= in_data.zsat;
        end
    end

    // Stage G
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            g_t_reg    <= f_doe_reg - 18'(f_d1460_reg) + 18'(f_d36524_reg)
                        - 18'(f_last_reg);
            g_doe_reg  <= f_doe_reg;
            g_era_reg  <= f_era_reg;
            g_zsat_reg <= f_zsat_reg;
        end
    end

    // Stage H: year of era, and day of era over seven for the weekday
    assign p365 = 36'(g_t_reg) * 36'(DIV365_M);
    assign p7   = 36'(g_doe_reg) * 36'(DIV7_M);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            h_yoe_reg  <= p365[34:26];
            h_q7_reg   <= p7[22:20];
            h_doe_reg  <= g_doe_reg;
            h_era_reg  <= g_era_reg;
            h_zsat_reg <= g_zsat_reg;
        end
    end

    // Stage I
    always_comb
    begin
        p100   = 19'(h_yoe_reg) * 19'(DIV100_M);
        rem7   = h_doe_reg[2:0] - 3'(h_q7_reg * 3'd7);
        wd_sum = 4'(rem7) + 4'd3;
        if (wd_sum >= 4'd7)
        begin
            wd_sum = wd_sum - 4'd7;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            i_y365_reg <= 18'(h_yoe_reg) * 18'(DAYS_PER_YEAR);
            i_y100_reg <= p100[17:16];
            i_yoe_reg  <= h_yoe_reg;
            i_doe_reg  <= h_doe_reg;
            i_era_reg  <= h_era_reg;
            i_zsat_reg <= h_zsat_reg;
            i_wd_reg   <= wd_sum[2:0];
        end
    end

    // Stage J: day of year; the February of this March-based year lies in year of era + 1
    always_comb
    begin
        yr_days  = i_y365_reg + 18'(i_yoe_reg[8:2]) - 18'(i_y100_reg);
        doy_wide = i_doe_reg - yr_days;
        yp1      = 10'(i_yoe_reg) + 10'd1;
        leap     = (yp1[1:0] == 2'd0) && (yp1 != 10'd100) && (yp1 != 10'd200)
                && (yp1 != 10'd300);
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            j_doy_reg  <= doy_wide[8:0];
            j_yoe_reg  <= i_yoe_reg;
            j_era_reg  <= i_era_reg;
            j_zsat_reg <= i_zsat_reg;
            j_wd_reg   <= i_wd_reg;
            j_leap_reg <= leap;
        end
    end

    // Stage K: month index of the March-based year
    assign p153 = (23'(j_doy_reg) * 23'd5 + 23'd2) * 23'(DIV153_M);

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            k_mp_reg   <= p153[22:19];
            k_doy_reg  <= j_doy_reg;
            k_yoe_reg  <= j_yoe_reg;
            k_era_reg  <= j_era_reg;
            k_zsat_reg <= j_zsat_reg;
            k_wd_reg   <= j_wd_reg;
            k_leap_reg <= j_leap_reg;
        end
    end

    // Stage L: calendar fields
    always_comb
    begin
        mm     = (k_mp_reg < 4'd10) ? (k_mp_reg + 4'd3) : (k_mp_reg - 4'd9);
        dom    = k_doy_reg - month_start(k_mp_reg) + 9'd1;
        year_v = 14'(k_yoe_reg) + 14'(k_era_reg) * 14'(YEARS_PER_ERA)
               - 14'(YEARS_PER_ERA) + ((mm <= 4'd2) ? 14'd1 : 14'd0);
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            l_zsat_reg  <= k_zsat_reg;
            l_year_reg  <= year_v;
            l_month_reg <= mm;
            l_day_reg   <= dom[4:0];
            l_wd_reg    <= k_wd_reg;
            l_mlen_reg  <= month_days(mm, k_leap_reg);
        end
    end

    assign rsp.valid          = vld_reg[NSTG-1];
    assign rsp.day_number_out = l_zsat_reg;
    assign rsp.year_out       = l_year_reg;
    assign rsp.month_out      = l_month_reg;
    assign rsp.day_out        = l_day_reg;
    assign rsp.weekday        = l_wd_reg;
    assign rsp.month_length   = l_mlen_reg;

endmodule

`default_nettype wire
